// File: src/decimating_sample_recorder_defines.svh
// ----------------------------------------------------------------------------
// Decimating sample recorder assertion macros
// Concurrent assertion helpers shared by the recorder RTL.
// ----------------------------------------------------------------------------
`ifndef DECIMATING_SAMPLE_RECORDER_DEFINES_SVH
`define DECIMATING_SAMPLE_RECORDER_DEFINES_SVH

`ifndef ASSERT_OFF
// Property checked at every clock edge outside reset.
`define DSR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Consequent checked in the cycle after the antecedent.
`define DSR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define DSR_ASSERT(lbl, clk, rst, prop, msg)
`define DSR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// File: src/dsr_pkg.sv
// ----------------------------------------------------------------------------
// Decimating sample recorder package
// Shared field widths, operation codes and the sequencer status type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dsr_pkg;

  // Operation codes of an input word.
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Sample field widths and the packed entry layout {virtual, resident, time}.
  localparam int VMEM_W  = 40;
  localparam int RSS_W   = 40;
  localparam int TIME_W  = 48;
  localparam int ENTRY_W = VMEM_W + RSS_W + TIME_W;

  // Counter and step limits.
  localparam int          CNT_W        = 32;
  localparam logic [31:0] CNT_MAX      = 32'hFFFF_FFFF;
  localparam logic [4:0]  STEP_LOG_MAX = 5'd31;

  // Status of the result the sequencer offers to the output register.
  typedef struct packed {
    logic valid;
    logic stored;
    logic hit;
  } dsr_res_t;

endpackage

// File: src/dsr_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsr_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/dsr_ctrl.sv
// ----------------------------------------------------------------------------
// Decimating sample recorder sequencer
// Holds the event count, decimation step and point count, decides whether a
// sample is kept, and runs the compaction sweep through the point memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsr_ctrl #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input word handshake and the fields the sequencer needs.
  input  logic                                 in_fire,
  output logic                                 in_ready,
  input  logic                                 op,
  input  logic [$clog2(MAX_POINTS)-1:0]        read_index,
  // Result offered to the output register.
  input  logic                                 res_ready,
  output dsr_pkg::dsr_res_t                    res,
  output logic [$clog2(MAX_POINTS)-1:0]        slot,
  output logic [31:0]                          step_size,
  output logic [31:0]                          event_count,
  output logic [$clog2(MAX_POINTS+1)-1:0]      point_count,
  // Point memory control.
  output logic                                 rd_en,
  output logic [$clog2(MAX_POINTS)-1:0]        rd_addr,
  output logic                                 wr_en,
  output logic [$clog2(MAX_POINTS)-1:0]        wr_addr,
  output logic                                 wr_sweep
);

  import dsr_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int PC_W  = $clog2(MAX_POINTS + 1);
  localparam int K_W   = IDX_W - 1;

  localparam logic [31:0]    MAX32   = 32'(MAX_POINTS);
  localparam logic [PC_W-1:0] MAX_PC = PC_W'(MAX_POINTS);
  localparam logic [K_W-1:0] HALF_M1 = K_W'(MAX_POINTS / 2 - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_REC   = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_RDATA = 3'd4;

  logic [2:0]       state, state_next;
  logic [31:0]      cnt, cnt_next;
  logic [31:0]      step, step_next;
  logic [4:0]       slog, slog_next;
  logic [PC_W-1:0]  pc, pc_next;
  logic             pend;
  logic [IDX_W-1:0] ridx;
  logic [K_W-1:0]   rd_k;
  logic [K_W-1:0]   wr_k;
  logic [IDX_W-1:0] idx_r;
  logic             store_r;

  // Decision terms for a record word.
  logic             keep;
  logic [31:0]      idx_raw;
  logic             do_cmp;
  logic [31:0]      idx_fin;
  logic             store;

  // Commit terms for the counters.
  logic             commit_path;
  logic             dbl;
  logic [31:0]      step_new;
  logic [4:0]       slog_new;
  logic [31:0]      cnt_new;
  logic [PC_W-1:0]  pc_half;
  logic [PC_W-1:0]  pc_new;
  logic             bump;
  logic             cur_stored;
  logic [IDX_W-1:0] cur_slot;
  logic             hit;
  logic             commit;

  // Keep test and slot of a record word: the step is a power of two.
  always_comb begin
    keep    = (cnt & (step - 32'd1)) == 32'd0;
    idx_raw = cnt >> slog;
    do_cmp  = keep && (idx_raw >= MAX32) && (slog != STEP_LOG_MAX);
    idx_fin = do_cmp ? (idx_raw >> 1) : idx_raw;
    store   = keep && (idx_fin < MAX32);
  end

  // Counter values after a record word, with the step doubled after a sweep.
  always_comb begin
    dbl      = (state == S_FIN);
    step_new = dbl ? (step << 1) : step;
    slog_new = dbl ? (slog + 5'd1) : slog;
    cnt_new  = (cnt == CNT_MAX) ? cnt : (cnt + 32'd1);
    pc_half  = dbl ? (pc >> 1) : pc;
    bump     = (cnt != CNT_MAX) && ((cnt_new & (step_new - 32'd1)) == 32'd0);
    pc_new   = (bump && (pc_half < MAX_PC)) ? (pc_half + PC_W'(1)) : pc_half;
  end

  // Result offered in the record, finish and read data states.
  always_comb begin
    commit_path = ((state == S_REC) && !do_cmp) || ((state == S_FIN) && !pend);
    hit         = PC_W'(ridx) < pc;
    cur_stored  = (state == S_FIN) ? store_r : store;
    cur_slot    = (state == S_FIN) ? idx_r : (store ? idx_fin[IDX_W-1:0] : '0);
    res.valid   = commit_path || (state == S_RDATA);
    res.stored  = commit_path && cur_stored;
    res.hit     = (state == S_RDATA) && hit;
    slot        = commit_path ? cur_slot : '0;
    step_size   = commit_path ? step_new : step;
    event_count = commit_path ? cnt_new : cnt;
    point_count = commit_path ? pc_new : pc;
    commit      = commit_path && res_ready;
  end

  // Memory port control: sweep writes use the forwarded read data.
  always_comb begin
    in_ready = (state == S_IDLE);
    rd_en    = 1'b0;
    rd_addr  = read_index;
    if (state == S_SWEEP) begin
      rd_en   = 1'b1;
      rd_addr = {rd_k, 1'b0};
    end else if (in_fire && (op == OP_READ)) begin
      rd_en = 1'b1;
    end
    wr_sweep = pend;
    wr_en    = pend || (commit && cur_stored);
    wr_addr  = pend ? IDX_W'(wr_k) : cur_slot;
  end

  // Next state and counter updates.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    step_next  = step;
    slog_next  = slog;
    pc_next    = pc;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = (op == OP_READ) ? S_RDATA : S_REC;
        end
      end
      S_REC: begin
        if (do_cmp) begin
          state_next = S_SWEEP;
        end else if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (rd_k == HALF_M1) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      S_RDATA: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (commit) begin
      cnt_next  = cnt_new;
      step_next = step_new;
      slog_next = slog_new;
      pc_next   = pc_new;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      step  <= 32'd1;
      slog  <= '0;
      pc    <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      step  <= step_next;
      slog  <= slog_next;
      pc    <= pc_next;
      pend  <= (state == S_SWEEP);
    end
  end

  // Word and sweep bookkeeping.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ridx <= read_index;
    end
    if ((state == S_REC) && do_cmp) begin
      rd_k    <= K_W'(1);
      idx_r   <= store ? idx_fin[IDX_W-1:0] : '0;
      store_r <= store;
    end else if (state == S_SWEEP) begin
      rd_k <= rd_k + K_W'(1);
    end
    if (state == S_SWEEP) begin
      wr_k <= rd_k;
    end
  end

endmodule

// File: src/decimating_sample_recorder.sv
// ----------------------------------------------------------------------------
// Decimating sample recorder
// Bounded trace of memory and time samples with adaptive decimation.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                      Carries
//   sample    sample_valid / sample_ready    operation, sample fields, index
//   result    result_valid / result_ready    store status, counters, point
//
// A word is accepted in the idle state, which issues the memory read of a read
// word; the record state decides and writes the point memory. A record that
// fills the buffer first runs the compaction sweep, which moves one entry per
// cycle through the single memory write port.
// Reset clears the counters only; the point memory has no clearing pass.
// A result waits in the output register while the next word is accepted; a
// stalled result holds back the following word's result and later words.
`timescale 1ns / 1ps
`include "decimating_sample_recorder_defines.svh"

module decimating_sample_recorder #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Sample channel.
  input  logic                                  sample_valid,
  output logic                                  sample_ready,
  input  logic                                  operation,
  input  logic [dsr_pkg::VMEM_W-1:0]            virtual_mem,
  input  logic [dsr_pkg::RSS_W-1:0]             rss_mem,
  input  logic [dsr_pkg::TIME_W-1:0]            time_stamp,
  input  logic [$clog2(MAX_POINTS)-1:0]         read_index,
  // Result channel.
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output logic                                  stored,
  output logic [$clog2(MAX_POINTS)-1:0]         slot,
  output logic [31:0]                           step_size,
  output logic [31:0]                           event_count,
  output logic [$clog2(MAX_POINTS+1)-1:0]       point_count,
  output logic                                  read_valid,
  output logic [dsr_pkg::VMEM_W-1:0]            read_virtual,
  output logic [dsr_pkg::RSS_W-1:0]             read_rss,
  output logic [dsr_pkg::TIME_W-1:0]            read_time
);

  import dsr_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int PC_W  = $clog2(MAX_POINTS + 1);
  localparam logic [PC_W-1:0] MAX_PC = PC_W'(MAX_POINTS);

  logic              in_fire;
  logic              res_ready;
  dsr_res_t          res;
  logic [IDX_W-1:0]  res_slot;
  logic [31:0]       res_step;
  logic [31:0]       res_count;
  logic [PC_W-1:0]   res_points;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic              wr_sweep;
  logic [ENTRY_W-1:0] wr_data;
  logic [VMEM_W-1:0] vmem;
  logic [RSS_W-1:0]  rss;
  logic [TIME_W-1:0] tstamp;

  assign in_fire   = sample_valid && sample_ready;
  assign res_ready = !result_valid || result_ready;

  // Sample fields of the word being recorded.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      vmem   <= virtual_mem;
      rss    <= rss_mem;
      tstamp <= time_stamp;
    end
  end

  // Sweep writes move a read entry down; otherwise the new sample is written.
  assign wr_data = wr_sweep ? rd_data : {vmem, rss, tstamp};

  dsr_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .in_ready    (sample_ready),
    .op          (operation),
    .read_index  (read_index),
    .res_ready   (res_ready),
    .res         (res),
    .slot        (res_slot),
    .step_size   (res_step),
    .event_count (res_count),
    .point_count (res_points),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_sweep    (wr_sweep)
  );

  dsr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_points (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output word valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_ready) begin
      result_valid <= res.valid;
    end
  end

  // Output word payload; read fields are zero unless the slot holds a point.
  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      stored       <= res.stored;
      slot         <= res_slot;
      step_size    <= res_step;
      event_count  <= res_count;
      point_count  <= res_points;
      read_valid   <= res.hit;
      read_virtual <= res.hit ? rd_data[ENTRY_W-1 -: VMEM_W] : '0;
      read_rss     <= res.hit ? rd_data[TIME_W +: RSS_W] : '0;
      read_time    <= res.hit ? rd_data[TIME_W-1:0] : '0;
    end
  end

  // Checks on the sequencer and the output word.
  `DSR_ASSERT(a_step_pow2, clk, rst, result_valid |-> $onehot(step_size), "step not one-hot")
  `DSR_ASSERT(a_points_bound, clk, rst, result_valid |-> point_count <= MAX_PC, "points too large")
  `DSR_ASSERT(a_busy_no_accept, clk, rst, !(sample_ready && res.valid), "word taken while busy")
  `DSR_ASSERT_NEXT(a_load_valid, clk, rst, res.valid && res_ready, result_valid, "result lost")

endmodule
